>>> rtl/core/tnpt_pkg.sv
// Package for the trajectory nearest-point tracker.
// Holds the sequencer state type, the input item kinds and register index codes;
// depends on nothing.
package tnpt_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_DIST,
        ST_SRCH_SUM,
        ST_SRCH_CMP,
        ST_STOP_CHK,
        ST_RUN_RD,
        ST_RUN_CHK,
        ST_FINISH,
        ST_EMIT
    } tnpt_state_t;

    // Input item kinds carried on s_tuser.
    typedef enum logic {
        CMD_APPEND = 1'b0,
        CMD_POSE   = 1'b1
    } tnpt_cmd_t;

    localparam logic [2:0] REG_DECIMATION = 3'd0;
    localparam logic [2:0] REG_SEARCH_WIN = 3'd1;
    localparam logic [2:0] REG_SEG_LEN    = 3'd2;
    localparam logic [2:0] REG_STOP_SPEED = 3'd3;
    localparam logic [2:0] REG_SKIP_STOP  = 3'd4;

    localparam int unsigned STOP_LEN_MAX = 8191;

endpackage

>>> rtl/core/tnpt_ram.sv
// Generic single-port synchronous RAM with a registered read.
// Depends on nothing.
module tnpt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8192
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Registered read; a same-cycle write returns the old data, which no caller uses.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> rtl/core/trajectory_nearest_point_tracker_top.sv
// Top level of the trajectory nearest-point tracker.
// Depends on tnpt_pkg and tnpt_ram.
//
// Appends are written to the store from the idle state. A processed pose reads the
// search window point by point, each through read, square, add and compare steps,
// then walks the stopped run one point per cycle, then emits one item. Processing
// time is set by the single port of the trajectory memory and the distance path,
// which is not overlapped across points. Poses that are held off or decimated are
// consumed in the idle state. One item is worked at a time, and no input is taken
// while a result waits.
module trajectory_nearest_point_tracker_top #(
    parameter int TRAJ_DEPTH = 8192
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: pos_x[23:0], pos_y[47:24], speed[63:48]
    input  logic [63:0] s_tdata,
    // tuser: cmd
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: start_index[12:0], point_count[26:13], stop_wait[39:27]
    output logic [39:0] m_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [14:0] cfg_wdata
);
    import tnpt_pkg::*;

    localparam int AW = $clog2(TRAJ_DEPTH);
    localparam int CW = AW + 1;

    tnpt_state_t state_reg, state_next;

    logic [7:0]  decimation_reg;
    logic [13:0] search_window_reg;
    logic [13:0] segment_length_reg;
    logic [14:0] stop_speed_reg;
    logic [7:0]  skip_after_stop_reg;

    logic [CW-1:0] stored_reg;
    logic [AW-1:0] goal_reg, goal_next;
    logic [7:0]    decim_reg, decim_next;
    logic [12:0]   hold_count_reg, hold_count_next;
    logic [12:0]   stop_length_reg, stop_length_next;

    logic signed [23:0] px_reg, py_reg;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] end_reg, end_next;
    logic [AW-1:0] best_reg, best_next;
    logic [50:0]   best_d_reg, best_d_next;
    logic          found_reg, found_next;
    logic [49:0]   sqx_reg, sqy_reg;
    logic [50:0]   d_reg;
    logic [39:0]   out_reg, out_next;
    logic          out_valid_reg, out_valid_next;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [63:0]   ram_wdata, ram_rdata;

    tnpt_ram #(.WIDTH(64), .DEPTH(TRAJ_DEPTH)) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    logic signed [23:0] rd_x, rd_y;
    logic signed [15:0] rd_v;
    logic signed [24:0] dx, dy;
    logic [24:0]        ax, ay;
    logic               rd_stopped;
    logic               accept;

    assign rd_x = ram_rdata[23:0];
    assign rd_y = ram_rdata[47:24];
    assign rd_v = ram_rdata[63:48];
    assign dx = 25'(rd_x) - 25'(px_reg);
    assign dy = 25'(rd_y) - 25'(py_reg);
    assign ax = dx[24] ? 25'(-dx) : 25'(dx);
    assign ay = dy[24] ? 25'(-dy) : 25'(dy);
    assign rd_stopped = $signed(17'(rd_v)) < $signed({2'b00, stop_speed_reg});

    assign s_tready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decimation_reg      <= 8'd10;
            search_window_reg   <= 14'd500;
            segment_length_reg  <= 14'd200;
            stop_speed_reg      <= 15'd50;
            skip_after_stop_reg <= 8'd30;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_DECIMATION: decimation_reg      <= cfg_wdata[7:0];
                REG_SEARCH_WIN: search_window_reg   <= cfg_wdata[13:0];
                REG_SEG_LEN:    segment_length_reg  <= cfg_wdata[13:0];
                REG_STOP_SPEED: stop_speed_reg      <= cfg_wdata;
                REG_SKIP_STOP:  skip_after_stop_reg <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // Squares are registered before the sum, the sum before the compare.
    always_ff @(posedge aclk) begin
        sqx_reg <= 50'(ax) * 50'(ax);
        sqy_reg <= 50'(ay) * 50'(ay);
        d_reg   <= 51'(sqx_reg) + 51'(sqy_reg);
        if (accept) begin
            px_reg <= s_tdata[23:0];
            py_reg <= s_tdata[47:24];
        end
    end

    // Sequencer and control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            stored_reg      <= '0;
            goal_reg        <= '0;
            decim_reg       <= '0;
            hold_count_reg  <= '0;
            stop_length_reg <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg       <= state_next;
            goal_reg        <= goal_next;
            decim_reg       <= decim_next;
            hold_count_reg  <= hold_count_next;
            stop_length_reg <= stop_length_next;
            out_valid_reg   <= out_valid_next;
            if (accept && s_tuser == CMD_APPEND && stored_reg < CW'(TRAJ_DEPTH)) begin
                stored_reg <= stored_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        end_reg    <= end_next;
        best_reg   <= best_next;
        best_d_reg <= best_d_next;
        found_reg  <= found_next;
        out_reg    <= out_next;
    end

    logic [CW+13:0] win_end;
    logic [CW+8:0]  ng;
    logic [CW-1:0]  remain;
    logic [CW-1:0]  run_len;

    always_comb begin
        state_next       = state_reg;
        goal_next        = goal_reg;
        decim_next       = decim_reg;
        hold_count_next  = hold_count_reg;
        stop_length_next = stop_length_reg;
        out_valid_next   = out_valid_reg;
        idx_next         = idx_reg;
        end_next         = end_reg;
        best_next        = best_reg;
        best_d_next      = best_d_reg;
        found_next       = found_reg;
        out_next         = out_reg;
        ram_we           = 1'b0;
        ram_addr         = idx_reg[AW-1:0];
        ram_wdata        = s_tdata;
        win_end          = (CW+14)'(goal_reg) + (CW+14)'(search_window_reg);
        ng               = (CW+9)'(idx_reg) + (CW+9)'(skip_after_stop_reg);
        remain           = stored_reg - CW'(goal_reg);
        run_len          = idx_reg - CW'(goal_reg);

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                ram_addr = stored_reg[AW-1:0];
                if (accept) begin
                    if (s_tuser == CMD_APPEND) begin
                        ram_we = stored_reg < CW'(TRAJ_DEPTH);
                    end else if (hold_count_reg < stop_length_reg) begin
                        hold_count_next = hold_count_reg + 1'b1;
                    end else if (decim_reg < decimation_reg) begin
                        decim_next = decim_reg + 1'b1;
                    end else if (stored_reg != '0) begin
                        decim_next = '0;
                        if (CW'(goal_reg) >= stored_reg) begin
                            goal_next = AW'(stored_reg - 1'b1);
                        end
                        state_next = ST_SRCH_RD;
                    end
                end
            end
            ST_SRCH_RD: begin
                // Set up the window on the clamped goal.
                idx_next   = CW'(goal_reg);
                best_next  = goal_reg;
                found_next = 1'b0;
                end_next   = (win_end > (CW+14)'(stored_reg)) ? stored_reg
                                                              : CW'(win_end);
                state_next = ST_SRCH_DIST;
                if (search_window_reg == '0) begin
                    state_next = ST_STOP_CHK;
                end
            end
            ST_SRCH_DIST: begin
                // Address is presented here; data lands next cycle.
                if (idx_reg >= end_reg) begin
                    goal_next  = best_reg;
                    state_next = ST_STOP_CHK;
                end else begin
                    state_next = ST_SRCH_SUM;
                end
            end
            ST_SRCH_SUM: begin
                // Squares are captured from read data this cycle.
                state_next = ST_SRCH_CMP;
            end
            ST_SRCH_CMP: begin
                // The sum of squares registers this cycle; compare next.
                state_next = ST_RUN_RD;
            end
            ST_RUN_RD: begin
                // Reused as the compare slot of the search.
                if (!found_reg || d_reg < best_d_reg) begin
                    best_d_next = d_reg;
                    best_next   = idx_reg[AW-1:0];
                    found_next  = 1'b1;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = ST_SRCH_DIST;
            end
            ST_STOP_CHK: begin
                // Read the goal point, then walk the stopped run.
                ram_addr   = goal_reg;
                idx_next   = CW'(goal_reg);
                state_next = ST_RUN_CHK;
            end
            ST_RUN_CHK: begin
                if (idx_reg < stored_reg && rd_stopped) begin
                    idx_next   = idx_reg + 1'b1;
                    ram_addr   = AW'(idx_reg + 1'b1);
                    if (idx_reg + 1'b1 >= stored_reg) begin
                        ram_addr = idx_reg[AW-1:0];
                    end
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (idx_reg != CW'(goal_reg)) begin
                    stop_length_next = (run_len > CW'(STOP_LEN_MAX)) ? 13'(STOP_LEN_MAX)
                                                                    : 13'(run_len);
                    goal_next = (ng >= (CW+9)'(stored_reg)) ? AW'(stored_reg - 1'b1)
                                                            : AW'(ng);
                end
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (hold_count_reg == stop_length_reg && stop_length_reg != '0) begin
                    hold_count_next  = '0;
                    stop_length_next = '0;
                    out_next[39:27]  = '0;
                end else begin
                    out_next[39:27] = (stop_length_reg > hold_count_reg)
                                    ? stop_length_reg - hold_count_reg : 13'd0;
                end
                out_next[12:0]  = 13'(goal_reg);
                out_next[26:13] = ((CW+14)'(segment_length_reg) < (CW+14)'(remain))
                                ? segment_length_reg : 14'(remain);
                out_valid_next  = 1'b1;
                state_next      = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

>>> rtl/core/tnpt_checker.sv
// Port-level checker for the trajectory nearest-point tracker.
// Depends on nothing; bound to the top level below.
module tnpt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // A waiting result item holds its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    // No input is taken while a result item waits.
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input taken while a result waits");

    // The segment never exceeds the store depth.
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[26:13] <= 14'd8192)
        else $error("point count out of range");

endmodule

bind trajectory_nearest_point_tracker_top tnpt_checker u_tnpt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> test/trajectory_nearest_point_tracker_top_tb.sv
// Self-checking testbench for the trajectory nearest-point tracker top level.
// Depends on tnpt_pkg and the RTL; a scoreboard class predicts every goal update.
`timescale 1ns / 1ps

module trajectory_nearest_point_tracker_top_tb;
    import tnpt_pkg::*;

    typedef struct {
        int start_index;
        int point_count;
        int stop_wait;
    } goal_rec_t;

    // Predicts goal updates from accepted items and checks emitted results.
    class goal_scoreboard_t;
        int px[8192];
        int py[8192];
        int pv[8192];
        int stored_points;
        int goal_index;
        int decim_count;
        int hold_count;
        int stop_length;
        int decimation;
        int search_window;
        int segment_length;
        int stop_speed;
        int skip_after_stop;
        goal_rec_t pending_goals[$];
        int errors;
        int checked;

        function new();
            stored_points = 0;
            goal_index = 0;
            decim_count = 0;
            hold_count = 0;
            stop_length = 0;
            decimation = 10;
            search_window = 500;
            segment_length = 200;
            stop_speed = 50;
            skip_after_stop = 30;
            errors = 0;
            checked = 0;
        endfunction

        function void set_reg(logic [2:0] idx, int value);
            case (idx)
                REG_DECIMATION: decimation = value & 'hFF;
                REG_SEARCH_WIN: search_window = value & 'h3FFF;
                REG_SEG_LEN:    segment_length = value & 'h3FFF;
                REG_STOP_SPEED: stop_speed = value & 'h7FFF;
                REG_SKIP_STOP:  skip_after_stop = value & 'hFF;
                default: ;
            endcase
        endfunction

        // Update the state for one accepted item; queue a result if one is due.
        function void note_input(tnpt_cmd_t c, logic signed [23:0] x,
                                 logic signed [23:0] y, logic signed [15:0] v);
            int last;
            int best;
            int i;
            int run;
            longint d;
            longint best_d;
            goal_rec_t rec;
            if (c == CMD_APPEND) begin
                if (stored_points < 8192) begin
                    px[stored_points] = x;
                    py[stored_points] = y;
                    pv[stored_points] = v;
                    stored_points++;
                end
                return;
            end
            if (hold_count < stop_length) begin
                hold_count++;
                return;
            end
            if (decim_count < decimation) begin
                decim_count++;
                return;
            end
            if (stored_points == 0) return;
            decim_count = 0;
            if (goal_index >= stored_points) goal_index = stored_points - 1;

            // Window search: the first point of least distance wins.
            last = goal_index + search_window;
            if (last > stored_points) last = stored_points;
            best = goal_index;
            best_d = -1;
            for (i = goal_index; i < last; i++) begin
                d = (longint'(px[i]) - x) * (longint'(px[i]) - x)
                  + (longint'(py[i]) - y) * (longint'(py[i]) - y);
                if (best_d < 0 || d < best_d) begin
                    best_d = d;
                    best = i;
                end
            end
            goal_index = best;

            // Stopped run: walk it, set the hold-off and jump past it.
            if (pv[goal_index] < stop_speed) begin
                i = goal_index;
                while (i < stored_points && pv[i] < stop_speed) i++;
                run = i - goal_index;
                stop_length = (run > STOP_LEN_MAX) ? STOP_LEN_MAX : run;
                goal_index = (i + skip_after_stop >= stored_points) ?
                             stored_points - 1 : i + skip_after_stop;
            end
            if (hold_count == stop_length && stop_length > 0) begin
                hold_count = 0;
                stop_length = 0;
            end

            rec.start_index = goal_index;
            rec.point_count = (segment_length < stored_points - goal_index) ?
                              segment_length : stored_points - goal_index;
            rec.stop_wait = (stop_length > hold_count) ? stop_length - hold_count : 0;
            pending_goals = {pending_goals, rec};
        endfunction

        function void check_result(logic [39:0] data);
            goal_rec_t rec;
            if (pending_goals.size() == 0) begin
                $error("unexpected result item %h", data);
                errors++;
                return;
            end
            rec = pending_goals.pop_front();
            checked++;
            if (data[12:0] != rec.start_index[12:0]) begin
                $error("start_index: expected %0d, actual %0d", rec.start_index, data[12:0]);
                errors++;
            end
            if (data[26:13] != rec.point_count[13:0]) begin
                $error("point_count: expected %0d, actual %0d", rec.point_count, data[26:13]);
                errors++;
            end
            if (data[39:27] != rec.stop_wait[12:0]) begin
                $error("stop_wait: expected %0d, actual %0d", rec.stop_wait, data[39:27]);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [14:0] cfg_wdata;

    goal_scoreboard_t sb;
    bit steady;
    int hold_request;
    bit hold_taken = 1'b0;
    int hold_left = 0;
    int items_sent;
    int walk_x;
    int walk_y;

    trajectory_nearest_point_tracker_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always #4 aclk = ~aclk;

    // Result side: check accepted items, then choose the next ready level.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
        if (hold_request > 0 && !hold_taken) begin
            hold_left = hold_request;
            hold_taken = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (steady) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= 26);
        end
    end

    // Offer one item, idling first at random, and note it once it is taken.
    task automatic send_item(tnpt_cmd_t c, int x, int y, int v);
        if (!steady && $urandom_range(99) < 26) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= c;
        s_tdata <= {v[15:0], y[23:0], x[23:0]};
        do @(posedge aclk); while (!s_tready);
        sb.note_input(c, x[23:0], y[23:0], v[15:0]);
        items_sent++;
    endtask

    // Stop offering and wait until every expected result has come out.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_goals.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, int value);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[14:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, value);
    endtask

    task automatic set_all(int dec, int win, int seg, int spd, int skip);
        write_reg(REG_DECIMATION, dec);
        write_reg(REG_SEARCH_WIN, win);
        write_reg(REG_SEG_LEN, seg);
        write_reg(REG_STOP_SPEED, spd);
        write_reg(REG_SKIP_STOP, skip);
    endtask

    // Append the next point of a random walk; speeds cluster near the stop level.
    task automatic append_walk_point();
        int r;
        int v;
        walk_x += $urandom_range(0, 4000) - 2000;
        walk_y += $urandom_range(0, 4000) - 2000;
        r = $urandom_range(99);
        if (r < 30) v = $urandom_range(0, 60);
        else if (r < 40) v = $urandom_range(0, 65535);
        else v = $urandom_range(100, 5000);
        if ($urandom_range(99) < 5) send_item(CMD_APPEND, $urandom, $urandom, v);
        else send_item(CMD_APPEND, walk_x, walk_y, v);
    endtask

    // Pose near a stored point, or anywhere now and then.
    task automatic send_pose();
        int idx;
        if (sb.stored_points == 0 || $urandom_range(99) < 10) begin
            send_item(CMD_POSE, $urandom, $urandom, $urandom);
        end else begin
            idx = $urandom_range(0, sb.stored_points - 1);
            if ($urandom_range(1)) idx = sb.goal_index + $urandom_range(0, 20);
            if (idx >= sb.stored_points) idx = sb.stored_points - 1;
            send_item(CMD_POSE, sb.px[idx] + $urandom_range(0, 600) - 300,
                      sb.py[idx] + $urandom_range(0, 600) - 300, $urandom);
        end
    endtask

    task automatic random_phase(int count, int append_pct);
        repeat (count) begin
            if ($urandom_range(99) < append_pct) append_walk_point();
            else send_pose();
        end
        drain();
    endtask

    initial begin
        sb = new();
        aclk = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        steady = 1'b0;
        hold_request = 0;
        items_sent = 0;
        walk_x = 0;
        walk_y = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: decimated poses, then a pose with an empty store.
        send_item(CMD_POSE, 0, 0, 0);
        send_item(CMD_POSE, -1, -1, -1);
        drain();
        write_reg(REG_DECIMATION, 0);
        send_item(CMD_POSE, 100, 100, 0);
        // Field extremes, a tie pair and a stopped run.
        send_item(CMD_APPEND, -8388608, 8388607, -32768);
        send_item(CMD_APPEND, 8388607, -8388608, 32767);
        send_item(CMD_APPEND, 5000, 5000, 1000);
        send_item(CMD_APPEND, 5000, 5000, 2000);
        send_item(CMD_APPEND, 9000, 9000, 0);
        send_item(CMD_APPEND, 9100, 9000, 10);
        send_item(CMD_APPEND, 9200, 9000, 49);
        send_item(CMD_APPEND, 9300, 9000, 50);
        send_item(CMD_APPEND, 0, 0, 300);
        send_item(CMD_POSE, 8388607, -8388608, 0);
        send_item(CMD_POSE, -8388608, 8388607, 0);
        send_item(CMD_POSE, 5000, 5000, 0);
        send_item(CMD_POSE, 9000, 9000, 0);
        send_item(CMD_POSE, 9000, 9000, 0);
        send_item(CMD_POSE, 9000, 9000, 0);
        send_item(CMD_POSE, 9000, 9000, 0);
        send_item(CMD_POSE, 0, 0, 0);
        drain();

        // Random phases across register settings, extremes among them.
        set_all(10, 500, 200, 50, 30);
        random_phase(120, 45);
        set_all(0, 1, 1, 0, 0);
        random_phase(100, 30);
        set_all(3, 0, 0, 32767, 255);
        random_phase(80, 30);

        // Wide window with no idling; the receiver holds off so input backs up.
        set_all(0, 8192, 8192, 2000, 5);
        steady = 1'b1;
        random_phase(40, 40);
        hold_request = 3000;
        random_phase(60, 30);
        steady = 1'b0;

        set_all(255, 20, 100, 60, 2);
        repeat (150) send_pose();
        drain();

        // Short window with a long segment.
        set_all(0, 4, 8191, 50, 1);
        repeat (3) append_walk_point();
        repeat (12) send_pose();
        drain();
        repeat (200) @(posedge aclk);

        $display("Sent %0d items and checked %0d goal results over several register settings,",
                 items_sent, sb.checked);
        $display("including stopped runs, ties, field extremes and receiver back-pressure.");
        if (sb.errors == 0 && sb.pending_goals.size() == 0) begin
            $display("trajectory_nearest_point_tracker_top_tb OK");
        end else begin
            $display("trajectory_nearest_point_tracker_top_tb NOT OK");
        end
        $finish;
    end

    // Overall time limit.
    initial begin
        #50ms;
        $display("trajectory_nearest_point_tracker_top_tb NOT OK");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/tnpt_pkg.sv
rtl/core/tnpt_ram.sv
rtl/core/trajectory_nearest_point_tracker_top.sv
rtl/core/tnpt_checker.sv
test/trajectory_nearest_point_tracker_top_tb.sv
